>>> rtl/rpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared types and constants of the ray / plane intersection unit.
// ----------------------------------------------------------------------------
package rpi_pkg;

  // quotient bits of t, magnitude width of den, divider remainder width
  localparam int unsigned QW = 31;
  localparam int unsigned DW = 64;
  localparam int unsigned RW = DW + QW + 1;

  typedef enum logic [2:0] {
    CFG_POINT_X  = 3'd0,
    CFG_POINT_Y  = 3'd1,
    CFG_POINT_Z  = 3'd2,
    CFG_NORMAL_X = 3'd3,
    CFG_NORMAL_Y = 3'd4,
    CFG_NORMAL_Z = 3'd5,
    CFG_EXTENT   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [31:0] ray_origin_z;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
  } ray_t;

  typedef struct packed {
    logic               is_hit;
    logic        [30:0] distance;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               saturated;
  } result_t;

  // data that rides alongside the division
  typedef struct packed {
    logic miss;
    logic sat;
    ray_t ray;
  } side_t;

endpackage

>>> rtl/rpi_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_divider
// Pipelined restoring divider: one overflow check stage, then one quotient
// bit per stage, most significant first.
// ----------------------------------------------------------------------------
module rpi_divider (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [rpi_pkg::RW-1:0]  num_i,
  input  logic [rpi_pkg::DW-1:0]  den_i,
  input  rpi_pkg::side_t          side_i,
  output logic                    out_valid_o,
  output logic [rpi_pkg::QW-1:0]  quo_o,
  output rpi_pkg::side_t          side_o
);

  localparam int unsigned QW = rpi_pkg::QW;
  localparam int unsigned RW = rpi_pkg::RW;
  localparam int unsigned DW = rpi_pkg::DW;

  logic [QW:0]          valid_q;
  logic [RW-1:0]        rem_q  [QW+1];
  logic [DW-1:0]        den_q  [QW+1];
  logic [QW-1:0]        quo_q  [QW+1];
  rpi_pkg::side_t       side_q [QW+1];
  rpi_pkg::side_t       side_d;

  // quotient would not fit in QW bits
  always_comb begin
    side_d     = side_i;
    side_d.sat = num_i >= (RW'(den_i) << QW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i;
    den_q[0]  <= den_i;
    quo_q[0]  <= '0;
    side_q[0] <= side_d;
  end

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [RW-1:0] sub;
    logic          ge;

    always_comb begin
      sub = RW'(den_q[g]) << (QW - 1 - g);
      ge  = rem_q[g] >= sub;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g+1] <= 1'b0;
      end else begin
        valid_q[g+1] <= valid_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g+1]  <= ge ? rem_q[g] - sub : rem_q[g];
      den_q[g+1]  <= den_q[g];
      quo_q[g+1]  <= {quo_q[g][QW-2:0], ge};
      side_q[g+1] <= side_q[g];
    end
  end

  assign out_valid_o = valid_q[QW];
  assign quo_o       = quo_q[QW];
  assign side_o      = side_q[QW];

endmodule

>>> rtl/ray_plane_intersect_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_plane_intersect_unit
// Fixed-point ray / plane intersection with optional square bound.
// ----------------------------------------------------------------------------
// A new ray may be started in every cycle; busy stays low. Each ray gives one
// result, marked by done_o; it passes through the dot product stages, the
// 32-stage divider (overflow check plus one quotient bit per stage) and the
// hit point stages. The result cannot be held off, so it must be taken in the
// cycle done_o is high. The user must write plane registers through the cfg
// port only while no ray is in flight; the block itself does not enforce it.
module ray_plane_intersect_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  rpi_pkg::ray_t      ray_i,
  output logic               done_o,
  output rpi_pkg::result_t   result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned RW  = rpi_pkg::RW;
  localparam int unsigned DW  = rpi_pkg::DW;
  localparam int unsigned QW  = rpi_pkg::QW;
  localparam int unsigned NMW = 66;
  localparam int unsigned LAT = 4 + 1 + QW + 3;
  localparam logic [QW-1:0] T_MAX = {QW{1'b1}};

  // ---------------- configuration ----------------
  logic signed [31:0] point_q  [3];
  logic signed [31:0] normal_q [3];
  logic        [30:0] extent_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q[0]  <= '0;
      point_q[1]  <= '0;
      point_q[2]  <= '0;
      normal_q[0] <= '0;
      normal_q[1] <= 32'sd65536;
      normal_q[2] <= '0;
      extent_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rpi_pkg::CFG_POINT_X:  point_q[0]  <= cfg_data_i;
        rpi_pkg::CFG_POINT_Y:  point_q[1]  <= cfg_data_i;
        rpi_pkg::CFG_POINT_Z:  point_q[2]  <= cfg_data_i;
        rpi_pkg::CFG_NORMAL_X: normal_q[0] <= cfg_data_i;
        rpi_pkg::CFG_NORMAL_Y: normal_q[1] <= cfg_data_i;
        rpi_pkg::CFG_NORMAL_Z: normal_q[2] <= cfg_data_i;
        rpi_pkg::CFG_EXTENT:   extent_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: origin minus point ----------------
  logic               v0_q;
  rpi_pkg::ray_t      ray0_q;
  logic signed [32:0] diff0_q [3];

  always_ff @(posedge clk_i) begin
    ray0_q     <= ray_i;
    diff0_q[0] <= 33'(ray_i.ray_origin_x) - 33'(point_q[0]);
    diff0_q[1] <= 33'(ray_i.ray_origin_y) - 33'(point_q[1]);
    diff0_q[2] <= 33'(ray_i.ray_origin_z) - 33'(point_q[2]);
  end

  // ---------------- stage 1: products ----------------
  logic               v1_q;
  rpi_pkg::ray_t      ray1_q;
  logic signed [64:0] nprod1_q [3];
  logic signed [63:0] dprod1_q [3];

  always_ff @(posedge clk_i) begin
    ray1_q      <= ray0_q;
    nprod1_q[0] <= 65'(diff0_q[0]) * 65'(normal_q[0]);
    nprod1_q[1] <= 65'(diff0_q[1]) * 65'(normal_q[1]);
    nprod1_q[2] <= 65'(diff0_q[2]) * 65'(normal_q[2]);
    dprod1_q[0] <= 64'(ray0_q.ray_dir_x) * 64'(normal_q[0]);
    dprod1_q[1] <= 64'(ray0_q.ray_dir_y) * 64'(normal_q[1]);
    dprod1_q[2] <= 64'(ray0_q.ray_dir_z) * 64'(normal_q[2]);
  end

  // ---------------- stage 2: dot product sums ----------------
  logic               v2_q;
  rpi_pkg::ray_t      ray2_q;
  logic signed [66:0] num2_q;
  logic signed [66:0] den2_q;

  always_ff @(posedge clk_i) begin
    ray2_q <= ray1_q;
    num2_q <= 67'(nprod1_q[0]) + 67'(nprod1_q[1]) + 67'(nprod1_q[2]);
    den2_q <= 67'(dprod1_q[0]) + 67'(dprod1_q[1]) + 67'(dprod1_q[2]);
  end

  // ---------------- stage 3: signs and magnitudes ----------------
  logic               v3_q;
  logic [NMW-1:0]     nmag3_q;
  logic [DW-1:0]      dmag3_q;
  rpi_pkg::side_t     side3_q;
  logic [66:0]        nabs;
  logic [66:0]        dabs;
  logic               miss2;

  always_comb begin
    nabs  = num2_q[66] ? 67'(-num2_q) : 67'(num2_q);
    dabs  = den2_q[66] ? 67'(-den2_q) : 67'(den2_q);
    // no hit unless num and den are nonzero with opposite signs
    miss2 = (num2_q == '0) || (den2_q == '0) || (num2_q[66] == den2_q[66]);
  end

  always_ff @(posedge clk_i) begin
    nmag3_q      <= nabs[NMW-1:0];
    dmag3_q      <= dabs[DW-1:0];
    side3_q.miss <= miss2;
    side3_q.sat  <= 1'b0;
    side3_q.ray  <= ray2_q;
  end

  // ---------------- divider ----------------
  logic               vd;
  logic [QW-1:0]      quo;
  rpi_pkg::side_t     sided;
  logic               miss_d;

  assign miss_d = side3_q.miss;

  rpi_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .num_i       (RW'(nmag3_q) << FRAC_BITS),
    .den_i       (dmag3_q),
    .side_i      (side3_q),
    .out_valid_o (vd),
    .quo_o       (quo),
    .side_o      (sided)
  );

  // ---------------- stage m: t times direction ----------------
  logic               vm_q;
  logic [QW-1:0]      tm_q;
  logic               missm_q;
  logic               satm_q;
  rpi_pkg::ray_t      raym_q;
  logic signed [63:0] tprodm_q [3];
  logic [QW-1:0]      t_d;

  assign t_d = sided.sat ? T_MAX : quo;

  always_ff @(posedge clk_i) begin
    tm_q        <= t_d;
    missm_q     <= sided.miss;
    satm_q      <= sided.sat;
    raym_q      <= sided.ray;
    tprodm_q[0] <= $signed({33'd0, t_d}) * 64'(sided.ray.ray_dir_x);
    tprodm_q[1] <= $signed({33'd0, t_d}) * 64'(sided.ray.ray_dir_y);
    tprodm_q[2] <= $signed({33'd0, t_d}) * 64'(sided.ray.ray_dir_z);
  end

  // ---------------- stage h: hit point ----------------
  logic               vh_q;
  logic [QW-1:0]      th_q;
  logic               missh_q;
  logic               sath_q;
  logic signed [65:0] hit_q [3];

  always_ff @(posedge clk_i) begin
    th_q     <= tm_q;
    missh_q  <= missm_q;
    sath_q   <= satm_q;
    // arithmetic shift gives the floor
    hit_q[0] <= 66'(raym_q.ray_origin_x) + 66'(tprodm_q[0] >>> FRAC_BITS);
    hit_q[1] <= 66'(raym_q.ray_origin_y) + 66'(tprodm_q[1] >>> FRAC_BITS);
    hit_q[2] <= 66'(raym_q.ray_origin_z) + 66'(tprodm_q[2] >>> FRAC_BITS);
  end

  // ---------------- output: bound test and clamp ----------------
  logic               out_v_q;
  rpi_pkg::result_t   res_q;
  rpi_pkg::result_t   res_d;
  logic signed [65:0] off2  [3];
  logic signed [31:0] clamp [3];
  logic [2:0]         out_of_bound;
  logic [2:0]         clamped;
  logic signed [65:0] ext_s;

  always_comb begin
    ext_s = $signed({35'd0, extent_q});
    for (int a = 0; a < 3; a++) begin
      off2[a] = (hit_q[a] - 66'(point_q[a])) <<< 1;
      out_of_bound[a] = (extent_q != '0) && (normal_q[a] == '0) &&
                        ((off2[a] > ext_s) || (off2[a] < -ext_s));
      if (hit_q[a] > 66'sd2147483647) begin
        clamp[a]   = 32'sh7fffffff;
        clamped[a] = 1'b1;
      end else if (hit_q[a] < -66'sd2147483648) begin
        clamp[a]   = 32'sh80000000;
        clamped[a] = 1'b1;
      end else begin
        clamp[a]   = hit_q[a][31:0];
        clamped[a] = 1'b0;
      end
    end
    res_d = '0;
    if (!missh_q && (out_of_bound == '0)) begin
      res_d.is_hit    = 1'b1;
      res_d.distance  = th_q;
      res_d.point_x   = clamp[0];
      res_d.point_y   = clamp[1];
      res_d.point_z   = clamp[2];
      res_d.saturated = sath_q || (clamped != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      vm_q    <= 1'b0;
      vh_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      v0_q    <= start && !busy;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      vm_q    <= vd;
      vh_q    <= vm_q;
      out_v_q <= vh_q;
    end
  end

  assign done_o   = out_v_q;
  assign result_o = res_q;

  // ---------------- assertions ----------------
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result without a matching request");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.is_hit) |->
      (result_o.distance == '0 && !result_o.saturated && result_o.point_x == '0))
    else $error("miss result not cleared");

  a_miss_flow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && miss_d) |-> ##(QW + 4) (done_o && !result_o.is_hit))
    else $error("miss turned into a hit");

endmodule
